// File: hw/rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  // Characters with a special role in the expression stream.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_TERM  = 8'h00;

  // Error codes carried on each result beat.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;

  // Datapath actions requested by the controller.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP_EMIT,
    ACT_POP_DROP,
    ACT_EMIT_ITEM,
    ACT_FLUSH
  } act_e;

  typedef struct packed {
    logic       load;
    act_e       act;
    logic [1:0] err;
  } cmd_t;

  typedef struct packed {
    logic item_end;
    logic item_open;
    logic item_close;
    logic item_op;
    logic cnt_zero;
    logic cnt_full;
    logic top_open;
    logic top_rel;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/itp_datapath.sv
`default_nettype none

module itp_datapath import itp_pkg::*; #(
  parameter int StackDepth = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_symbol_o,
  output logic            last_o,
  output logic [1:0]      error_o
);

  localparam int CntW  = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);

  logic [7:0]      item_sym_q;
  logic            item_end_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      top_q;
  logic [7:0]      stack_mem [StackDepth];
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0] cnt_dec;
  logic            we;

  // The newest result is held back one step so that the last flag can be set
  // once the item is known to produce nothing more.
  logic            hold_valid_q;
  logic [7:0]      hold_sym_q;
  logic [1:0]      hold_err_q;

  logic            out_valid_q;
  logic [7:0]      out_sym_q;
  logic            out_last_q;
  logic [1:0]      out_err_q;

  logic            out_free;
  logic            new_res;
  logic [7:0]      new_sym;
  logic [1:0]      new_err;

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.item_end   = item_end_q;
  assign sts_o.item_open  = item_sym_q == CH_OPEN;
  assign sts_o.item_close = item_sym_q == CH_CLOSE;
  assign sts_o.item_op    = item_sym_q == CH_GT || item_sym_q == CH_LT ||
                            item_sym_q == CH_OR || item_sym_q == CH_AND;
  assign sts_o.cnt_zero   = cnt_q == '0;
  assign sts_o.cnt_full   = cnt_q == CntW'(StackDepth);
  assign sts_o.top_open   = top_q == CH_OPEN;
  assign sts_o.top_rel    = top_q == CH_GT || top_q == CH_LT;
  assign sts_o.out_free   = out_free;

  assign we = cmd_i.act == ACT_PUSH;

  always_comb begin
    cnt_d = cnt_q;
    case (cmd_i.act)
      ACT_PUSH:     cnt_d = cnt_q + CntW'(1);
      ACT_POP_EMIT: cnt_d = cnt_q - CntW'(1);
      ACT_POP_DROP: cnt_d = cnt_q - CntW'(1);
      default:      cnt_d = cnt_q;
    endcase
  end

  assign cnt_dec = cnt_d - CntW'(1);
  assign rd_addr = (cnt_d == '0) ? '0 : cnt_dec[AddrW-1:0];

  always_comb begin
    new_res = 1'b0;
    new_sym = item_sym_q;
    new_err = cmd_i.err;
    case (cmd_i.act)
      ACT_POP_EMIT: begin
        new_res = 1'b1;
        new_sym = top_q;
        new_err = ERR_NONE;
      end
      ACT_EMIT_ITEM: begin
        new_res = 1'b1;
      end
      default: new_res = 1'b0;
    endcase
  end

  // Stack storage; top_q mirrors the entry at the new top after each step.
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[cnt_q[AddrW-1:0]] <= item_sym_q;
    end
    top_q <= we ? item_sym_q : stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_sym_q <= end_of_expr_i ? CH_TERM : symbol_i;
      item_end_q <= end_of_expr_i;
    end
    if (new_res) begin
      hold_sym_q <= new_sym;
      hold_err_q <= new_err;
    end
    if ((new_res || cmd_i.act == ACT_FLUSH) && hold_valid_q) begin
      out_sym_q  <= hold_sym_q;
      out_err_q  <= hold_err_q;
      out_last_q <= cmd_i.act == ACT_FLUSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (new_res) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.act == ACT_FLUSH) begin
        hold_valid_q <= 1'b0;
      end
      if ((new_res || cmd_i.act == ACT_FLUSH) && hold_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign last_o       = out_last_q;
  assign error_o      = out_err_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == ACT_PUSH |-> !sts_o.cnt_full)
    else $error("push issued on a full stack");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_POP_EMIT || cmd_i.act == ACT_POP_DROP) |-> !sts_o.cnt_zero)
    else $error("pop issued on an empty stack");

  a_cnt_only_on_stack_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act != ACT_PUSH && cmd_i.act != ACT_POP_EMIT && cmd_i.act != ACT_POP_DROP)
    |=> $stable(cnt_q))
    else $error("stack count moved without a stack operation");

  a_move_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_res || cmd_i.act == ACT_FLUSH) |-> out_free)
    else $error("result moved into an occupied output register");

endmodule

`default_nettype wire

// File: hw/rtl/itp_controller.sv
`default_nettype none

module itp_controller import itp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.act  = ACT_NONE;
    cmd_o.err  = ERR_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WORK;
        end
      end
      S_WORK: begin
        if (sts_i.out_free) begin
          if (sts_i.item_end) begin
            if (!sts_i.cnt_zero) begin
              cmd_o.act = ACT_POP_EMIT;
            end else begin
              cmd_o.act = ACT_EMIT_ITEM;
              state_d   = S_FLUSH;
            end
          end else if (sts_i.item_open) begin
            if (sts_i.cnt_full) begin
              cmd_o.act = ACT_EMIT_ITEM;
              cmd_o.err = ERR_OVERFLOW;
            end else begin
              cmd_o.act = ACT_PUSH;
            end
            state_d = S_FLUSH;
          end else if (sts_i.item_close) begin
            if (sts_i.cnt_zero) begin
              cmd_o.act = ACT_EMIT_ITEM;
              cmd_o.err = ERR_UNMATCH;
              state_d   = S_FLUSH;
            end else if (sts_i.top_open) begin
              cmd_o.act = ACT_POP_DROP;
              state_d   = S_FLUSH;
            end else begin
              cmd_o.act = ACT_POP_EMIT;
            end
          end else if (sts_i.item_op) begin
            if (!sts_i.cnt_zero && sts_i.top_rel) begin
              cmd_o.act = ACT_POP_EMIT;
            end else if (sts_i.cnt_full) begin
              cmd_o.act = ACT_EMIT_ITEM;
              cmd_o.err = ERR_OVERFLOW;
              state_d   = S_FLUSH;
            end else begin
              cmd_o.act = ACT_PUSH;
              state_d   = S_FLUSH;
            end
          end else begin
            cmd_o.act = ACT_EMIT_ITEM;
            state_d   = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.act = ACT_FLUSH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_WORK)
    else $error("item loaded without entering the work state");

  a_stack_ops_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.act == ACT_PUSH || cmd_o.act == ACT_POP_EMIT || cmd_o.act == ACT_POP_DROP)
    |-> state_q == S_WORK)
    else $error("stack operation outside the work state");

  a_flush_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == ACT_FLUSH |=> !in_stall_o)
    else $error("flush did not reopen the input");

endmodule

`default_nettype wire

// File: hw/rtl/infix_to_postfix_converter.sv
`default_nettype none

// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+-----------------------------------
// in       | input     | in_valid_i / in_stall_o   | symbol_i, end_of_expr_i
// out      | output    | out_valid_o / out_stall_i | out_symbol_o, last_o, error_o
//
// One input beat is taken in the idle state, then the item runs one stack step per
// cycle while the output register can take a result: a plain character, '(' or an
// operator with nothing to pop passes the work and flush states, and each entry
// popped by ')', an operator or the end item adds a work step of one push or pop.
// Reset clears the stack count, the controller state and the result valid flags;
// stack contents need no clearing since only pushed entries are ever read.
// A stalled output freezes the work and flush states until the result register drains.

module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_symbol_o,
  output logic            last_o,
  output logic [1:0]      error_o
);

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t cmd;
  sts_t sts;

  itp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the item register, the operator stack, a one-deep
  // hold stage that lets the last flag be set late, and the output register.
  itp_datapath #(
    .StackDepth (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .symbol_i      (symbol_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_o  (out_symbol_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

endmodule

`default_nettype wire

// File: bench/itp_postfix_checker.sv
`default_nettype none

// Watches both channels of the converter. It predicts the postfix beats for
// every accepted input beat and compares each accepted output beat against
// the oldest prediction still waiting.
module itp_postfix_checker import itp_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_of_expr_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_symbol_i,
  input  wire logic       last_i,
  input  wire logic [1:0] error_i,
  output int              fail_count_o,
  output int              pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic [1:0] err;
  } postfix_beat_t;

  logic [7:0]    op_stack [STACK_DEPTH];
  int            op_depth = 0;
  postfix_beat_t burst[$];
  postfix_beat_t postfix_due[$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic release_beat(input logic [7:0] s, input logic [1:0] e);
    postfix_beat_t b;
    b.sym  = s;
    b.last = 1'b0;
    b.err  = e;
    burst.push_back(b);
  endtask

  // A push onto a full stack is dropped and reported as an overflow beat.
  task automatic push_op(input logic [7:0] c);
    if (op_depth >= STACK_DEPTH) begin
      release_beat(c, ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = c;
      op_depth++;
    end
  endtask

  task automatic predict_postfix(input logic [7:0] s, input logic eoe);
    bit         matched;
    logic [7:0] t;
    burst.delete();
    matched = 1'b0;
    if (eoe) begin
      while (op_depth > 0) begin
        op_depth--;
        release_beat(op_stack[op_depth], ERR_NONE);
      end
      release_beat(CH_TERM, ERR_NONE);
    end else if (s == CH_OPEN) begin
      push_op(s);
    end else if (s == CH_CLOSE) begin
      while (op_depth > 0 && !matched) begin
        op_depth--;
        if (op_stack[op_depth] == CH_OPEN) begin
          matched = 1'b1;
        end else begin
          release_beat(op_stack[op_depth], ERR_NONE);
        end
      end
      if (!matched) begin
        release_beat(CH_CLOSE, ERR_UNMATCH);
      end
    end else if (s == CH_GT || s == CH_LT || s == CH_OR || s == CH_AND) begin
      // Pending relational operators go out first, down to a paren or a
      // logical operator.
      while (op_depth > 0) begin
        t = op_stack[op_depth - 1];
        if (t == CH_OPEN || t == CH_OR || t == CH_AND) break;
        op_depth--;
        release_beat(t, ERR_NONE);
      end
      push_op(s);
    end else begin
      release_beat(s, ERR_NONE);
    end
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last = 1'b1;
    end
    foreach (burst[k]) postfix_due.push_back(burst[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    postfix_beat_t head;
    if (!rst_ni) begin
      op_depth = 0;
      postfix_due.delete();
    end else begin
      // Results are registered, so a beat leaving now never belongs to an
      // input beat taken at the same edge; compare before predicting.
      if (out_valid_i && !out_stall_i) begin
        if (postfix_due.size() == 0) begin
          $error("unexpected result beat: out_symbol %h last %b error %0d",
                 out_symbol_i, last_i, error_i);
          mismatches++;
        end else begin
          head = postfix_due.pop_front();
          if (out_symbol_i !== head.sym) begin
            $error("out_symbol: expected %h, got %h", head.sym, out_symbol_i);
            mismatches++;
          end
          if (last_i !== head.last) begin
            $error("last: expected %b, got %b", head.last, last_i);
            mismatches++;
          end
          if (error_i !== head.err) begin
            $error("error: expected %0d, got %0d", head.err, error_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_postfix(symbol_i, end_of_expr_i);
      end
    end
    pending_o <= postfix_due.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

// Stimulus and verdict for the infix to postfix converter. The checker beside
// the block does all prediction and comparison; this module only produces
// input beats, throttles the output side and decides pass or fail.
module tb_top import itp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 32;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] symbol = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic       last;
  logic [1:0] out_error;
  int         fail_count;
  int         pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         beats_sent = 0;

  logic [7:0] op_chars [4] = '{CH_GT, CH_LT, CH_OR, CH_AND};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .symbol_i     (symbol),
    .end_of_expr_i(end_of_expr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_symbol_o (out_symbol),
    .last_o       (last),
    .error_o      (out_error)
  );

  itp_postfix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .symbol_i     (symbol),
    .end_of_expr_i(end_of_expr),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_symbol_i (out_symbol),
    .last_i       (last),
    .error_i      (out_error),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver stalls independently of out_valid, so stalls also land on
  // cycles where the block is busy popping its stack.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offers one beat and returns at the edge where it is taken. Valid stays
  // high on return, so back-to-back beats never drop it; it is lowered only
  // when the sender decides to idle or waits for the results to drain.
  task automatic send_beat(input logic [7:0] s, input logic e);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid    <= 1'b1;
    symbol      <= s;
    end_of_expr <= e;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Holds the sender off until every predicted result beat has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Operands are mostly lowercase letters, otherwise any byte that has no
  // special meaning to the converter.
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h61, 8'h7A));
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_OPEN || c == CH_CLOSE || c == CH_GT || c == CH_LT ||
               c == CH_OR || c == CH_AND);
    return c;
  endfunction

  // A balanced expression: operands joined by operators, with nested parens.
  task automatic send_well_formed();
    int  len;
    int  depth;
    int  n;
    bit  need_operand;
    len = $urandom_range(1, 14);
    depth = 0;
    n = 0;
    need_operand = 1'b1;
    forever begin
      if (need_operand) begin
        if (depth < 6 && $urandom_range(0, 3) == 0) begin
          send_beat(CH_OPEN, 1'b0);
          depth++;
        end else begin
          send_beat(pick_operand(), 1'b0);
          need_operand = 1'b0;
        end
      end else if (depth > 0 && (n >= len || $urandom_range(0, 2) == 0)) begin
        send_beat(CH_CLOSE, 1'b0);
        depth--;
      end else if (n >= len) begin
        break;
      end else begin
        send_beat(op_chars[$urandom_range(0, 3)], 1'b0);
        need_operand = 1'b1;
      end
      n++;
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Chains of mostly relational operators, which pop each other.
  task automatic send_relational_chain();
    send_beat(pick_operand(), 1'b0);
    repeat ($urandom_range(1, 8)) begin
      send_beat(($urandom_range(0, 4) == 0) ? op_chars[$urandom_range(2, 3)]
                                            : op_chars[$urandom_range(0, 1)], 1'b0);
      send_beat(pick_operand(), 1'b0);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Piles up parens, logical operators and '<' toward and often past the stack depth so
  // that overflow beats appear, then unwinds part of it and drains the rest.
  task automatic send_deep_nest();
    repeat ($urandom_range(28, 40)) begin
      case ($urandom_range(0, 4))
        0, 1:    send_beat(CH_OPEN, 1'b0);
        2:       send_beat(CH_AND, 1'b0);
        3:       send_beat(CH_OR, 1'b0);
        default: send_beat(CH_LT, 1'b0);
      endcase
      if ($urandom_range(0, 3) == 0) send_beat(pick_operand(), 1'b0);
    end
    repeat ($urandom_range(0, 6)) send_beat(CH_CLOSE, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Random mix of valid tokens with no grammar, so stray and missing
  // closing parens are common.
  task automatic send_broken();
    repeat ($urandom_range(3, 14)) begin
      case ($urandom_range(0, 3))
        0:       send_beat(CH_OPEN, 1'b0);
        1:       send_beat(CH_CLOSE, 1'b0);
        2:       send_beat(op_chars[$urandom_range(0, 3)], 1'b0);
        default: send_beat(pick_operand(), 1'b0);
      endcase
    end
    if ($urandom_range(0, 4) != 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Arbitrary bytes; the end flag is sometimes set in the middle.
  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    end
    if ($urandom_range(0, 1) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Random traffic up to a running beat total. Each phase opens with a pause
  // that lets every outstanding result drain first.
  task automatic run_phase(input int beat_goal);
    int pick;
    drain_results();
    while (beats_sent < beat_goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) send_well_formed();
      else if (pick < 14) send_relational_chain();
      else if (pick < 15) send_deep_nest();
      else if (pick < 18) send_broken();
      else send_noise();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 25;
    stall_pct <= 78;

    // Directed beats: byte extremes, a zero symbol that is not an end,
    // every operator, relational pops stopping at a paren, a closing paren
    // with and without a match, and end beats with the stack non-empty or empty.
    send_beat(8'h61, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_OPEN, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(CH_LT, 1'b0);
    send_beat(8'h63, 1'b0);
    send_beat(CH_GT, 1'b0);
    send_beat(8'h64, 1'b0);
    send_beat(CH_OR, 1'b0);
    send_beat(8'h65, 1'b0);
    send_beat(CH_AND, 1'b0);
    send_beat(8'h66, 1'b0);
    send_beat(CH_CLOSE, 1'b0);
    send_beat(CH_CLOSE, 1'b0);
    send_beat(CH_LT, 1'b0);
    send_beat(CH_OPEN, 1'b0);
    send_beat(CH_CLOSE, 1'b0);
    send_beat(CH_CLOSE, 1'b0);
    send_beat(CH_AND, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(CH_CLOSE, 1'b1);

    run_phase(160);

    gap_pct = 78;
    stall_pct <= 25;
    run_phase(300);

    gap_pct = 0;
    stall_pct <= 0;
    run_phase(450);

    drain_results();
    // A full stack drain plus terminator, with margin, so any stray beat
    // after the last expected one is still seen.
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
